/* src/rgbyv_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to YV12 converter package
// Shared widths, coefficients, codes and the control structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rgbyv_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int DIM_W      = 12;   // frame_width / frame_height registers
  localparam int POS_W      = 11;   // column and row counters
  localparam int LUMA_IDX_W = 22;
  localparam int CHR_IDX_W  = 20;
  localparam int ADDR_W     = 23;
  localparam int PCT_W      = 9;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Q16 luma weights, and chroma gains for (B-Y) and (R-Y)
  localparam logic [15:0] COEF_YR  = 16'd19595;
  localparam logic [15:0] COEF_YG  = 16'd38470;
  localparam logic [15:0] COEF_YB  = 16'd7471;
  localparam logic [17:0] COEF_CB  = 18'd37028;
  localparam logic [17:0] COEF_CR  = 18'd46727;
  localparam logic [26:0] CHROMA_OFFSET = 27'd8388608;  // 128 << 16

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 199728
  localparam logic [17:0] RECIP_100   = 18'd167773;
  localparam int          RECIP_SHIFT = 24;

  localparam logic [PIX_W-1:0] MID_GRAY = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;

  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_PERCENT = 2'd3;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_V = 2'd1,
    PLANE_U = 2'd2
  } plane_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;    // clamped to MAX_WIDTH
    logic [DIM_W-1:0] height;   // clamped to MAX_HEIGHT
    logic             mono;
    logic [PCT_W-1:0] luma_pct;
  } cfg_t;

  typedef struct packed {
    logic   load;      // capture pixel, apply first_pixel
    logic   luma_en;   // luma sum and plane size
    logic   scale_en;  // luma scale and chroma products
    logic   div_en;    // divide by 100, finish chroma
    logic   advance;   // step position counters
    plane_t plane;     // write currently offered
  } cmd_t;

  typedef struct packed {
    logic chroma;      // pixel sits at even column and even row
  } status_t;

endpackage

/* src/rgb_to_yv12_pixel_converter_top.sv */
// ----------------------------------------------------------------------------
// RGB to YV12 pixel converter
// Converts a raster stream of BGR pixels into planar YV12 byte writes.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    blue, green, red, first_pixel
//   out      source     out_valid / out_ready  plane_sel, byte_addr,
//                                              sample_value, last_of_pixel
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel at a time: accept, then the arithmetic steps (luma sum,
// scale and chroma products, divide by 100), then the writes in turn:
// Y alone for a luma-only pixel, Y, V and U for a pixel with chroma.
// Each write is held until transferred; out_ready low stalls the sequence.
// Synchronous reset restores the register defaults and zeroes the counters;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module rgb_to_yv12_pixel_converter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbyv_pkg::PIX_W-1:0]       blue,
  input  logic [rgbyv_pkg::PIX_W-1:0]       green,
  input  logic [rgbyv_pkg::PIX_W-1:0]       red,
  input  logic                              first_pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        plane_sel,
  output logic [rgbyv_pkg::ADDR_W-1:0]      byte_addr,
  output logic [rgbyv_pkg::PIX_W-1:0]       sample_value,
  output logic                              last_of_pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbyv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbyv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rgbyv_pkg::cfg_t    cfg;
  rgbyv_pkg::cmd_t    cmd;
  rgbyv_pkg::status_t status;

  rgbyv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rgbyv_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .last_of_pixel (last_of_pixel),
    .status        (status),
    .cmd           (cmd)
  );

  rgbyv_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .first_pixel  (first_pixel),
    .plane_sel    (plane_sel),
    .byte_addr    (byte_addr),
    .sample_value (sample_value)
  );

endmodule

/* src/rgbyv_cfg.sv */
// ----------------------------------------------------------------------------
// RGB to YV12 converter configuration registers
// Register file behind the write channel; geometry is clamped on the way out.
// ----------------------------------------------------------------------------
module rgbyv_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbyv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbyv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rgbyv_pkg::cfg_t                   cfg
);

  logic [rgbyv_pkg::DIM_W-1:0] frame_width;
  logic [rgbyv_pkg::DIM_W-1:0] frame_height;
  logic                        mono_mode;
  logic [rgbyv_pkg::PCT_W-1:0] luma_percent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbyv_pkg::DIM_W'(640);
      frame_height <= rgbyv_pkg::DIM_W'(480);
      mono_mode    <= 1'b0;
      luma_percent <= rgbyv_pkg::PCT_W'(100);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbyv_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[rgbyv_pkg::DIM_W-1:0];
        rgbyv_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[rgbyv_pkg::DIM_W-1:0];
        rgbyv_pkg::REG_MONO_MODE:    mono_mode    <= cfg_data[0];
        rgbyv_pkg::REG_LUMA_PERCENT: luma_percent <= cfg_data[rgbyv_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width    = (frame_width > rgbyv_pkg::DIM_MAX_W) ? rgbyv_pkg::DIM_MAX_W : frame_width;
    cfg.height   = (frame_height > rgbyv_pkg::DIM_MAX_H) ? rgbyv_pkg::DIM_MAX_H
                                                         : frame_height;
    cfg.mono     = mono_mode;
    cfg.luma_pct = luma_percent;
  end

endmodule

/* src/rgbyv_ctrl.sv */
// ----------------------------------------------------------------------------
// RGB to YV12 converter controller
// Sequences one pixel through the arithmetic steps and the plane writes.
// ----------------------------------------------------------------------------
module rgbyv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 last_of_pixel,
  input  rgbyv_pkg::status_t   status,
  output rgbyv_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LUMA  = 7'b0000010,
    S_SCALE = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_OUT_Y = 7'b0010000,
    S_OUT_V = 7'b0100000,
    S_OUT_U = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_xfer;

  assign out_xfer = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    last_of_pixel = 1'b0;
    cmd           = '0;
    cmd.plane     = rgbyv_pkg::PLANE_Y;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_next = S_LUMA;
      end
      S_LUMA: begin
        cmd.luma_en = 1'b1;
        state_next  = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        state_next = S_OUT_Y;
      end
      S_OUT_Y: begin
        out_valid     = 1'b1;
        last_of_pixel = ~status.chroma;
        if (out_xfer) begin
          if (status.chroma) begin
            state_next = S_OUT_V;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_OUT_V: begin
        out_valid = 1'b1;
        cmd.plane = rgbyv_pkg::PLANE_V;
        if (out_xfer) state_next = S_OUT_U;
      end
      S_OUT_U: begin
        out_valid     = 1'b1;
        last_of_pixel = 1'b1;
        cmd.plane     = rgbyv_pkg::PLANE_U;
        if (out_xfer) begin
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/rgbyv_dp.sv */
// ----------------------------------------------------------------------------
// RGB to YV12 converter datapath
// Pixel capture, luma and chroma arithmetic, position counters and the
// write address / sample selection.
// ----------------------------------------------------------------------------
module rgbyv_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  rgbyv_pkg::cfg_t                   cfg,
  input  rgbyv_pkg::cmd_t                   cmd,
  output rgbyv_pkg::status_t                status,
  input  logic [rgbyv_pkg::PIX_W-1:0]       blue,
  input  logic [rgbyv_pkg::PIX_W-1:0]       green,
  input  logic [rgbyv_pkg::PIX_W-1:0]       red,
  input  logic                              first_pixel,
  output logic [1:0]                        plane_sel,
  output logic [rgbyv_pkg::ADDR_W-1:0]      byte_addr,
  output logic [rgbyv_pkg::PIX_W-1:0]       sample_value
);

  localparam int PW = rgbyv_pkg::PIX_W;
  localparam int AW = rgbyv_pkg::ADDR_W;

  // floor(acc / 65536) clamped to 0..255
  function automatic logic [PW-1:0] chroma_sat(input logic signed [26:0] acc);
    logic signed [10:0] q;
    q = acc[26:16];
    if (q < 0) begin
      chroma_sat = '0;
    end else if (q > 11'sd255) begin
      chroma_sat = rgbyv_pkg::PIX_MAX;
    end else begin
      chroma_sat = q[PW-1:0];
    end
  endfunction

  logic [PW-1:0] b_q, g_q, r_q;

  logic [rgbyv_pkg::POS_W-1:0]      col_count, row_count;
  logic [rgbyv_pkg::LUMA_IDX_W-1:0] luma_index;
  logic [rgbyv_pkg::CHR_IDX_W-1:0]  chroma_index;

  logic [23:0]            luma_sum;
  logic [PW-1:0]          y_q;
  logic [AW-1:0]          plane_q;
  logic [AW-1:0]          base_u;
  logic [16:0]            scaled_q;
  logic signed [26:0]     cb_prod_q, cr_prod_q;
  logic signed [8:0]      diff_b, diff_r;
  logic [34:0]            recip_prod;
  logic [10:0]            y_div;
  logic [PW-1:0]          yout_q, cb_q, cr_q;

  logic                           col_wrap, row_wrap;

  // Luma sum in Q16
  assign luma_sum = 24'(rgbyv_pkg::COEF_YR) * 24'(r_q)
                  + 24'(rgbyv_pkg::COEF_YG) * 24'(g_q)
                  + 24'(rgbyv_pkg::COEF_YB) * 24'(b_q);

  assign diff_b = $signed({1'b0, b_q}) - $signed({1'b0, y_q});
  assign diff_r = $signed({1'b0, r_q}) - $signed({1'b0, y_q});

  assign recip_prod = 35'(scaled_q) * 35'(rgbyv_pkg::RECIP_100);
  assign y_div      = recip_prod[34:rgbyv_pkg::RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_q <= blue;
      g_q <= green;
      r_q <= red;
    end
    if (cmd.luma_en) begin
      y_q     <= luma_sum[23:16];
      plane_q <= AW'(cfg.width) * AW'(cfg.height);
    end
    if (cmd.scale_en) begin
      base_u    <= plane_q + (plane_q >> 2);
      scaled_q  <= 17'(y_q) * 17'(cfg.luma_pct);
      cb_prod_q <= 27'(diff_b) * $signed({9'd0, rgbyv_pkg::COEF_CB});
      cr_prod_q <= 27'(diff_r) * $signed({9'd0, rgbyv_pkg::COEF_CR});
    end
    if (cmd.div_en) begin
      yout_q <= (y_div > 11'(rgbyv_pkg::PIX_MAX)) ? rgbyv_pkg::PIX_MAX : y_div[PW-1:0];
      if (cfg.mono) begin
        cb_q <= rgbyv_pkg::MID_GRAY;
        cr_q <= rgbyv_pkg::MID_GRAY;
      end else begin
        cb_q <= chroma_sat(cb_prod_q + $signed(rgbyv_pkg::CHROMA_OFFSET));
        cr_q <= chroma_sat(cr_prod_q + $signed(rgbyv_pkg::CHROMA_OFFSET));
      end
    end
  end

  // Position counters
  assign col_wrap = (12'(col_count) + 12'd1) >= cfg.width;
  assign row_wrap = (12'(row_count) + 12'd1) >= cfg.height;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count    <= '0;
      row_count    <= '0;
      luma_index   <= '0;
      chroma_index <= '0;
    end else if (cmd.load && first_pixel) begin
      col_count    <= '0;
      row_count    <= '0;
      luma_index   <= '0;
      chroma_index <= '0;
    end else if (cmd.advance) begin
      luma_index <= luma_index + 1'b1;
      if (status.chroma) chroma_index <= chroma_index + 1'b1;
      if (col_wrap) begin
        col_count <= '0;
        if (row_wrap) begin
          // end of frame: restart everything
          row_count    <= '0;
          luma_index   <= '0;
          chroma_index <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  assign status.chroma = ~col_count[0] & ~row_count[0];

  // Write selection
  always_comb begin
    plane_sel = cmd.plane;
    case (cmd.plane)
      rgbyv_pkg::PLANE_V: begin
        byte_addr    = plane_q + AW'(chroma_index);
        sample_value = cr_q;
      end
      rgbyv_pkg::PLANE_U: begin
        byte_addr    = base_u + AW'(chroma_index);
        sample_value = cb_q;
      end
      default: begin
        byte_addr    = AW'(luma_index);
        sample_value = yout_q;
      end
    endcase
  end

endmodule

/* dv/rgb_to_yv12_pixel_converter_tb.sv */
// ----------------------------------------------------------------------------
// RGB to YV12 pixel converter testbench
// Streams BGR pixels through the converter under several frame geometries,
// luma scales and chroma modes. A local model predicts every plane write,
// and each write that leaves the block is checked field by field against it.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import rgbyv_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             first;
  } pixel_t;

  typedef struct {
    plane_t            plane;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  value;
    logic              last;
  } yv_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      blue = '0;
  logic [PIX_W-1:0]      green = '0;
  logic [PIX_W-1:0]      red = '0;
  logic                  first_pixel = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            plane_sel;
  logic [ADDR_W-1:0]     byte_addr;
  logic [PIX_W-1:0]      sample_value;
  logic                  last_of_pixel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rgb_to_yv12_pixel_converter_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the register file and the raster position
  int unsigned frame_w = 640;
  int unsigned frame_h = 480;
  logic        mono_on = 1'b0;
  int unsigned luma_pct = 100;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned luma_addr = 0;
  int unsigned chroma_addr = 0;

  pixel_t    pixel_q[$];
  yv_write_t yv_q[$];
  pixel_t    cur_px;

  int n_queued = 0;
  int n_accepted = 0;
  int n_writes = 0;
  int n_frames = 0;
  int n_settings = 1;
  int n_errors = 0;

  int burst_left = 8;
  int gap_left = 0;
  logic [31:0] stall_pat = '1;
  int          stall_age = 0;

  function automatic int chroma_byte(int diff, int gain);
    int acc;
    acc = diff * gain + int'(CHROMA_OFFSET);
    acc = acc >>> 16;
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc;
  endfunction

  // Work out the writes one pixel causes and advance the raster position
  function automatic void convert_pixel(pixel_t px);
    int unsigned w, h, y, y_out, base;
    int          cb, cr;
    logic        has_chroma;
    yv_write_t   wr;
    w = (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    h = (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
    if (px.first) begin
      col_pos = 0;
      row_pos = 0;
      luma_addr = 0;
      chroma_addr = 0;
    end
    y = (int'(COEF_YR) * px.red + int'(COEF_YG) * px.green
         + int'(COEF_YB) * px.blue) >> 16;
    if (mono_on) begin
      cb = int'(MID_GRAY);
      cr = int'(MID_GRAY);
    end else begin
      cb = chroma_byte(int'(px.blue) - int'(y), int'(COEF_CB));
      cr = chroma_byte(int'(px.red) - int'(y), int'(COEF_CR));
    end
    y_out = y;
    if (luma_pct != 100) begin
      y_out = y * luma_pct / 100;
      if (y_out > 255) y_out = 255;
    end
    base = w * h;
    has_chroma = !col_pos[0] && !row_pos[0];

    wr.plane = PLANE_Y;
    wr.addr  = ADDR_W'(luma_addr);
    wr.value = PIX_W'(y_out);
    wr.last  = !has_chroma;
    yv_q.push_back(wr);
    if (has_chroma) begin
      wr.plane = PLANE_V;
      wr.addr  = ADDR_W'(base + chroma_addr);
      wr.value = PIX_W'(cr);
      wr.last  = 1'b0;
      yv_q.push_back(wr);
      wr.plane = PLANE_U;
      wr.addr  = ADDR_W'(base + base / 4 + chroma_addr);
      wr.value = PIX_W'(cb);
      wr.last  = 1'b1;
      yv_q.push_back(wr);
      chroma_addr++;
    end

    luma_addr++;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        luma_addr = 0;
        chroma_addr = 0;
        n_frames++;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  // Pixel driver: bursts of random length with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        convert_pixel(cur_px);
        n_accepted++;
      end
      if (in_valid && !in_ready) begin
        // hold the pixel until it transfers
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        cur_px = pixel_q.pop_front();
        blue <= cur_px.blue;
        green <= cur_px.green;
        red <= cur_px.red;
        first_pixel <= cur_px.first;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Write monitor; out_ready follows a rotating stall pattern
  always @(posedge clk) begin : write_monitor
    yv_write_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (yv_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected write: expected none, actual plane %0d addr %0d value %0d",
                   $time, plane_sel, byte_addr, sample_value);
        end else begin
          want = yv_q.pop_front();
          check_field("plane_sel", want.plane, plane_sel);
          check_field("byte_addr", want.addr, byte_addr);
          check_field("sample_value", want.value, sample_value);
          check_field("last_of_pixel", want.last, last_of_pixel);
          n_writes++;
        end
      end
      out_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
      stall_age++;
      if (stall_age == 96) begin
        stall_age = 0;
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = $urandom | 32'h1;
          2: stall_pat = 32'h3333_3333;
          default: stall_pat = ($urandom & $urandom) | 32'h1;
        endcase
      end
    end
  end

  task automatic push_pixel(int b, int g, int r, logic first);
    pixel_t px;
    px.blue = PIX_W'(b);
    px.green = PIX_W'(g);
    px.red = PIX_W'(r);
    px.first = first;
    pixel_q.push_back(px);
    n_queued++;
  endtask

  function automatic int rand_byte();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(0, 9))
      6: return $urandom_range(0, 3);
      7: return $urandom_range(0, 4095);
      8: return 2 * $urandom_range(1, 6) + 1;
      9: return MAX_WIDTH;
      default: return 2 * $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int rand_pct();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 100;
      2: return 511;
      3: return $urandom_range(0, 400);
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // Wait until every queued pixel has transferred and every write has come back
  task automatic wait_idle();
    while (n_accepted != n_queued || yv_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  frame_w = value & 12'hFFF;
      REG_FRAME_HEIGHT: frame_h = value & 12'hFFF;
      REG_MONO_MODE:    mono_on = value[0];
      REG_LUMA_PERCENT: luma_pct = value & 9'h1FF;
      default: ;
    endcase
  endtask

  task automatic set_config(int w, int h, int mono, int pct);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_MONO_MODE, mono);
    write_reg(REG_LUMA_PERCENT, pct);
    n_settings++;
  endtask

  initial begin
    int n_items;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: primaries, black, white and the chroma clamp corners
    push_pixel(0, 0, 0, 1'b1);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(0, 0, 255, 1'b0);
    push_pixel(0, 255, 0, 1'b0);
    push_pixel(255, 0, 0, 1'b0);
    push_pixel(255, 255, 0, 1'b0);
    push_pixel(255, 0, 255, 1'b0);
    push_pixel(0, 255, 255, 1'b0);
    push_pixel(128, 128, 128, 1'b0);
    push_pixel(1, 2, 3, 1'b0);
    wait_idle();

    // Tiny frame: wrap once, restart in mid-frame
    set_config(2, 2, 0, 100);
    push_pixel(10, 200, 30, 1'b0);
    push_pixel(255, 0, 0, 1'b0);
    push_pixel(0, 0, 255, 1'b0);
    push_pixel(90, 90, 90, 1'b0);
    push_pixel(0, 255, 255, 1'b0);
    push_pixel(255, 255, 255, 1'b1);
    push_pixel(7, 77, 177, 1'b0);
    wait_idle();

    // Monochrome with luma forced to zero
    set_config(4, 2, 1, 0);
    push_pixel(255, 255, 255, 1'b1);
    push_pixel(0, 0, 255, 1'b0);
    push_pixel(255, 0, 0, 1'b0);
    push_pixel(40, 80, 120, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_config(MAX_WIDTH, MAX_HEIGHT, 0, 511);
        1: set_config(4095, 4095, 1, 400);
        2: set_config(0, 0, 0, 99);
        3: set_config(1, 3, 0, 101);
        default: set_config(rand_dim(), rand_dim(), $urandom_range(0, 1), rand_pct());
      endcase
      n_items = $urandom_range(16, 28);
      for (int i = 0; i < n_items; i++)
        push_pixel(rand_byte(), rand_byte(), rand_byte(),
                   (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0));
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Converted %0d pixels into %0d checked writes under %0d register settings,",
             n_accepted, n_writes, n_settings);
    $display("with %0d frame wraps and %0d mismatches.", n_frames, n_errors);
    if (n_errors == 0 && yv_q.size() == 0) begin
      $display("** rgb_to_yv12_pixel_converter_top: PASSED **");
    end else begin
      $display("** rgb_to_yv12_pixel_converter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout: %0d pixels queued, %0d transferred, %0d writes outstanding",
             n_queued, n_accepted, yv_q.size());
    $display("** rgb_to_yv12_pixel_converter_top: FAILED **");
    $finish;
  end

endmodule
